@@ hdl/ctm_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ctm_pkg: shared types and constants for the connection table manager
// Holds the state encoding, the table entry layout, action codes, packet
// flag positions and configuration register indexes.
// ----------------------------------------------------------------------------
package ctm_pkg;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PK_RD,
        ST_PK_EV,
        ST_PK_UPD,
        ST_PK_DEC,
        ST_TK_RD,
        ST_TK_EV
    } t_state;

    // One table entry as kept in the entry memory.
    typedef struct packed {
        logic [31:0] id;
        logic [31:0] network;
        logic [47:0] node;
        logic [15:0] peer_port;
        logic [15:0] local_port;
        logic [31:0] last_seq;
        logic [7:0]  timeout;
    } t_entry;

    // Result action codes.
    localparam logic [2:0] ACT_ACK     = 3'd0;
    localparam logic [2:0] ACT_REJECT  = 3'd1;
    localparam logic [2:0] ACT_COMMAND = 3'd2;
    localparam logic [2:0] ACT_INTERRO = 3'd3;
    localparam logic [2:0] ACT_FINISH  = 3'd4;

    // Packet flag bit positions.
    localparam int FL_OPEN    = 0;
    localparam int FL_FIN     = 1;
    localparam int FL_ACK     = 2;
    localparam int FL_REJ     = 3;
    localparam int FL_CONLESS = 4;
    localparam int FL_CMD     = 5;

    // Configuration register indexes.
    localparam logic [1:0] CFG_TICK_PERIOD    = 2'd0;
    localparam logic [1:0] CFG_TIMEOUT_RELOAD = 2'd1;
    localparam logic [1:0] CFG_ACCEPTING_PORT = 2'd2;

    // Fixed values.
    localparam logic [7:0]  PKT_TYPE        = 8'h66;
    localparam logic [15:0] TICK_PERIOD_RST = 16'd1200;
    localparam logic [7:0]  TIMEOUT_RST     = 8'd2;
    localparam logic [31:0] LCG_MUL         = 32'd1664525;
    localparam logic [31:0] LCG_ADD         = 32'd1013904223;
    localparam int          MAX_RESULTS     = 16;

endpackage
`default_nettype wire

@@ hdl/connection_table_manager.sv @@
`default_nettype none
// A packet result is registered after a table scan that reads each entry in turn, with a read
// state and an evaluate state per entry, followed by the update and/or decide state.
// No new transaction is taken until the sequencer is back in idle: after a packet's scan and
// reply, and after a sweeping tick's scan; other ticks and dropped packets leave it idle.
// Output stalls can hold the update, decide and sweep states.
// Reset is synchronous, active low; it frees all slots through per-slot valid bits.
// ----------------------------------------------------------------------------
// connection_table_manager
// Keeps a table of open connections in a synchronous memory and answers
// packets and ticks with ack, reject, dispatch, interrogate or finish results.
// ----------------------------------------------------------------------------
module connection_table_manager #(
    parameter int NUM_SLOTS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration port
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [15:0] i_cfg_data,
    // Input channel
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_func,
    input  wire logic [7:0]  i_packet_type,
    input  wire logic [5:0]  i_flags,
    input  wire logic [31:0] i_conn_id,
    input  wire logic [31:0] i_seqnum,
    input  wire logic [31:0] i_src_network,
    input  wire logic [47:0] i_src_node,
    input  wire logic [15:0] i_src_port,
    input  wire logic [15:0] i_dst_port,
    // Output channel
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [2:0]       o_action,
    output logic [3:0]       o_slot,
    output logic [31:0]      o_reply_conn_id,
    output logic [31:0]      o_reply_seqnum,
    output logic [31:0]      o_peer_network,
    output logic [47:0]      o_peer_node,
    output logic [15:0]      o_peer_port,
    output logic [15:0]      o_local_port,
    output logic             o_last
);

    localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(NUM_SLOTS - 1);

    // State and configuration registers.
    ctm_pkg::t_state r_state, n_state;
    logic [IW-1:0]        r_idx, n_idx;
    logic [NUM_SLOTS-1:0] r_valid, n_valid;
    logic                 r_hit, n_hit;
    logic [IW-1:0]        r_cur, n_cur;
    ctm_pkg::t_entry      r_hent, n_hent;
    logic                 r_dup, n_dup;
    logic                 r_free, n_free;
    logic [IW-1:0]        r_fr, n_fr;
    logic [4:0]           r_cnt, n_cnt;
    logic [15:0]          r_phase, n_phase;
    logic [31:0]          r_rand, n_rand;
    logic [15:0]          r_tick_period;
    logic [7:0]           r_timeout_reload;
    logic [15:0]          r_accepting_port;

    // Captured input transaction.
    logic [5:0]  r_flags;
    logic [31:0] r_cid, r_seq, r_net;
    logic [47:0] r_node;
    logic [15:0] r_sport, r_dport;

    // Output register.
    logic        r_o_valid;
    logic [2:0]  r_o_action;
    logic [3:0]  r_o_slot;
    logic [31:0] r_o_cid, r_o_seq, r_o_net;
    logic [47:0] r_o_node;
    logic [15:0] r_o_pport, r_o_lport;
    logic        r_o_last;

    // Memory and its access signals.
    ctm_pkg::t_entry r_mem [NUM_SLOTS];
    ctm_pkg::t_entry r_rd;
    logic            mem_we;
    logic [IW-1:0]   mem_wa;
    ctm_pkg::t_entry mem_wd;

    // Result load signals.
    logic            ld;
    logic [2:0]      ld_action;
    logic [3:0]      ld_slot;
    logic [31:0]     ld_cid, ld_seq, ld_net;
    logic [47:0]     ld_node;
    logic [15:0]     ld_pport, ld_lport;
    logic            ld_last;

    logic            in_acc;
    logic            out_free;
    logic            above;
    logic [15:0]     period;
    ctm_pkg::t_entry upd;
    ctm_pkg::t_entry opn;
    logic            regress;
    logic            conless;
    logic [31:0]     rid0;
    logic [3:0]      slot0;

    assign o_stall  = (r_state != ctm_pkg::ST_IDLE);
    assign in_acc   = i_valid && !o_stall;
    assign out_free = !r_o_valid || !i_stall;
    assign period   = (r_tick_period == 16'd0) ? 16'd1 : r_tick_period;
    assign conless  = r_flags[ctm_pkg::FL_CONLESS];
    assign rid0     = conless ? 32'd0 : r_cid;
    assign slot0    = r_hit ? 4'(r_cur) : 4'd0;
    assign regress  = (r_seq < r_hent.last_seq);

    // Whether any occupied slot lies past the current index.
    always_comb begin
        above = 1'b0;
        for (int k = 0; k < NUM_SLOTS; k++) begin
            if (r_valid[k] && (k > int'(r_idx))) begin
                above = 1'b1;
            end
        end
    end

    // Entry memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd <= r_mem[r_idx];
    end

    // Sequencer next state and memory and output controls.
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_valid = r_valid;
        n_hit   = r_hit;
        n_cur   = r_cur;
        n_hent  = r_hent;
        n_dup   = r_dup;
        n_free  = r_free;
        n_fr    = r_fr;
        n_cnt   = r_cnt;
        n_phase = r_phase;
        n_rand  = r_rand;
        mem_we  = 1'b0;
        mem_wa  = r_idx;
        mem_wd  = r_rd;
        ld        = 1'b0;
        ld_action = ctm_pkg::ACT_REJECT;
        ld_slot   = slot0;
        ld_cid    = rid0;
        ld_seq    = r_seq;
        ld_net    = r_net;
        ld_node   = r_node;
        ld_pport  = r_sport;
        ld_lport  = r_dport;
        ld_last   = 1'b1;
        upd       = r_hent;
        opn.id         = r_rand;
        opn.network    = r_net;
        opn.node       = r_node;
        opn.peer_port  = r_sport;
        opn.local_port = r_dport;
        opn.last_seq   = 32'd0;
        opn.timeout    = r_timeout_reload;

        case (r_state)
            ctm_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_idx = '0;
                    if (i_func) begin
                        n_rand  = r_rand * ctm_pkg::LCG_MUL + ctm_pkg::LCG_ADD;
                        n_phase = (17'(r_phase) + 17'd1 >= 17'(period)) ? 16'd0
                                                                        : r_phase + 16'd1;
                        n_cnt = '0;
                        if (r_phase == 16'd0) begin
                            n_state = ctm_pkg::ST_TK_RD;
                        end
                    end else if (i_packet_type == ctm_pkg::PKT_TYPE) begin
                        n_hit   = 1'b0;
                        n_dup   = 1'b0;
                        n_free  = 1'b0;
                        n_state = ctm_pkg::ST_PK_RD;
                    end
                end
            end
            ctm_pkg::ST_PK_RD: begin
                n_state = ctm_pkg::ST_PK_EV;
            end
            ctm_pkg::ST_PK_EV: begin
                // Lookup, duplicate peer check and first free slot in one scan.
                if (r_valid[r_idx]) begin
                    if (!conless && !r_hit && r_rd.id == r_cid) begin
                        n_hit  = 1'b1;
                        n_cur  = r_idx;
                        n_hent = r_rd;
                    end
                    if (r_rd.network == r_net && r_rd.node == r_node &&
                        r_rd.peer_port == r_sport && r_rd.local_port == r_dport) begin
                        n_dup = 1'b1;
                    end
                end else if (!r_free) begin
                    n_free = 1'b1;
                    n_fr   = r_idx;
                end
                if (r_idx == LAST_IDX) begin
                    n_state = n_hit ? ctm_pkg::ST_PK_UPD : ctm_pkg::ST_PK_DEC;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = ctm_pkg::ST_PK_RD;
                end
            end
            ctm_pkg::ST_PK_UPD: begin
                // Refresh the matched entry; a sequence regression closes it.
                upd.timeout  = r_timeout_reload;
                upd.last_seq = r_hent.last_seq + (regress ? 32'd2 : 32'd1);
                if (out_free) begin
                    mem_we = 1'b1;
                    mem_wa = r_cur;
                    mem_wd = upd;
                    if (regress) begin
                        ld        = 1'b1;
                        ld_action = ctm_pkg::ACT_FINISH;
                        ld_slot   = 4'(r_cur);
                        ld_cid    = upd.id;
                        ld_seq    = upd.last_seq;
                        ld_net    = upd.network;
                        ld_node   = upd.node;
                        ld_pport  = upd.peer_port;
                        ld_lport  = upd.local_port;
                        n_valid[r_cur] = 1'b0;
                        n_state   = ctm_pkg::ST_IDLE;
                    end else begin
                        n_state = ctm_pkg::ST_PK_DEC;
                    end
                end
            end
            ctm_pkg::ST_PK_DEC: begin
                // Decide the packet's reply.
                ld = 1'b1;
                if (!conless && !r_hit && !r_flags[ctm_pkg::FL_OPEN]) begin
                    ld_action = ctm_pkg::ACT_REJECT;
                end else if (r_flags[ctm_pkg::FL_ACK]) begin
                    ld = 1'b0;
                end else if (r_flags[ctm_pkg::FL_OPEN]) begin
                    if (r_flags[ctm_pkg::FL_FIN] || conless || r_flags[ctm_pkg::FL_REJ] ||
                        r_dport != r_accepting_port || r_dup || !r_free) begin
                        ld_action = ctm_pkg::ACT_REJECT;
                    end else begin
                        mem_we  = out_free;
                        mem_wa  = r_fr;
                        mem_wd  = opn;
                        ld_slot = 4'(r_fr);
                        ld_cid  = r_rand;
                        if (out_free) begin
                            n_valid[r_fr] = (r_rand != 32'd0);
                        end
                        if (r_flags[ctm_pkg::FL_CMD]) begin
                            ld_action = ctm_pkg::ACT_COMMAND;
                            ld_seq    = r_seq + 32'd1;
                        end else begin
                            ld_action = ctm_pkg::ACT_ACK;
                        end
                    end
                end else if (r_flags[ctm_pkg::FL_FIN]) begin
                    if (r_hit) begin
                        ld_action = ctm_pkg::ACT_ACK;
                        if (out_free) begin
                            n_valid[r_cur] = 1'b0;
                        end
                    end else begin
                        ld_action = ctm_pkg::ACT_REJECT;
                    end
                end else if (r_flags[ctm_pkg::FL_CMD]) begin
                    ld_action = ctm_pkg::ACT_COMMAND;
                    ld_seq    = r_seq + 32'd1;
                end else begin
                    ld_action = ctm_pkg::ACT_REJECT;
                end
                if (!ld) begin
                    n_state = ctm_pkg::ST_IDLE;
                end else if (out_free) begin
                    n_state = ctm_pkg::ST_IDLE;
                end else begin
                    ld = 1'b0;
                end
            end
            ctm_pkg::ST_TK_RD: begin
                n_state = ctm_pkg::ST_TK_EV;
            end
            ctm_pkg::ST_TK_EV: begin
                // Age one entry, report it while results remain.
                upd          = r_rd;
                upd.timeout  = r_rd.timeout - 8'd1;
                upd.last_seq = r_rd.last_seq + 32'd1;
                ld_action = (upd.timeout == 8'd0) ? ctm_pkg::ACT_FINISH
                                                  : ctm_pkg::ACT_INTERRO;
                ld_slot   = 4'(r_idx);
                ld_cid    = upd.id;
                ld_seq    = upd.last_seq;
                ld_net    = upd.network;
                ld_node   = upd.node;
                ld_pport  = upd.peer_port;
                ld_lport  = upd.local_port;
                ld_last   = (r_cnt == 5'(ctm_pkg::MAX_RESULTS - 1)) || !above;
                if (!r_valid[r_idx] || r_cnt >= 5'(ctm_pkg::MAX_RESULTS) || out_free) begin
                    if (r_valid[r_idx]) begin
                        mem_we = 1'b1;
                        mem_wa = r_idx;
                        mem_wd = upd;
                        if (upd.timeout == 8'd0) begin
                            n_valid[r_idx] = 1'b0;
                        end
                        if (r_cnt < 5'(ctm_pkg::MAX_RESULTS)) begin
                            ld    = 1'b1;
                            n_cnt = r_cnt + 5'd1;
                        end
                    end
                    if (r_idx == LAST_IDX) begin
                        n_state = ctm_pkg::ST_IDLE;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = ctm_pkg::ST_TK_RD;
                    end
                end
            end
            default: begin
                n_state = ctm_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= ctm_pkg::ST_IDLE;
            r_valid          <= '0;
            r_phase          <= '0;
            r_rand           <= '0;
            r_cnt            <= '0;
            r_o_valid        <= 1'b0;
            r_tick_period    <= ctm_pkg::TICK_PERIOD_RST;
            r_timeout_reload <= ctm_pkg::TIMEOUT_RST;
            r_accepting_port <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_phase <= n_phase;
            r_rand  <= n_rand;
            r_cnt   <= n_cnt;
            if (ld) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    ctm_pkg::CFG_TICK_PERIOD:    r_tick_period    <= i_cfg_data;
                    ctm_pkg::CFG_TIMEOUT_RELOAD: r_timeout_reload <= i_cfg_data[7:0];
                    ctm_pkg::CFG_ACCEPTING_PORT: r_accepting_port <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // Scan bookkeeping, captured transaction and output payload.
    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_hit  <= n_hit;
        r_cur  <= n_cur;
        r_hent <= n_hent;
        r_dup  <= n_dup;
        r_free <= n_free;
        r_fr   <= n_fr;
        if (in_acc) begin
            r_flags <= i_flags;
            r_cid   <= i_conn_id;
            r_seq   <= i_seqnum;
            r_net   <= i_src_network;
            r_node  <= i_src_node;
            r_sport <= i_src_port;
            r_dport <= i_dst_port;
        end
        if (ld) begin
            r_o_action <= ld_action;
            r_o_slot   <= ld_slot;
            r_o_cid    <= ld_cid;
            r_o_seq    <= ld_seq;
            r_o_net    <= ld_net;
            r_o_node   <= ld_node;
            r_o_pport  <= ld_pport;
            r_o_lport  <= ld_lport;
            r_o_last   <= ld_last;
        end
    end

    assign o_valid         = r_o_valid;
    assign o_action        = r_o_action;
    assign o_slot          = r_o_slot;
    assign o_reply_conn_id = r_o_cid;
    assign o_reply_seqnum  = r_o_seq;
    assign o_peer_network  = r_o_net;
    assign o_peer_node     = r_o_node;
    assign o_peer_port     = r_o_pport;
    assign o_local_port    = r_o_lport;
    assign o_last          = r_o_last;

    // A sweep never reports more results than allowed.
    a_cnt_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 5'(ctm_pkg::MAX_RESULTS))
        else $error("sweep result count overflow");

    // A result is only loaded while a transaction is being worked on.
    a_ld_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ld |-> r_state != ctm_pkg::ST_IDLE)
        else $error("result loaded while idle");

    // A new connection is only written into a free slot.
    a_open_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we && r_state == ctm_pkg::ST_PK_DEC) |-> !r_valid[r_fr])
        else $error("open overwrites an occupied slot");

    // A result is never loaded over one that is still stalled.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && i_stall) |-> !ld)
        else $error("output register overrun");

endmodule
`default_nettype wire

@@ test/connection_table_manager_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// connection_table_manager_checker: result predictor and scoreboard
// Watches the configuration port and both channels of the connection table
// manager, keeps its own copy of the table, works out the results of every
// accepted transaction and compares each returned result field by field.
// ----------------------------------------------------------------------------
module connection_table_manager_checker
    import ctm_pkg::*;
#(
    parameter int NUM_SLOTS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        i_valid,
    input  wire logic        i_stall_in,
    input  wire logic        i_func,
    input  wire logic [7:0]  i_packet_type,
    input  wire logic [5:0]  i_flags,
    input  wire logic [31:0] i_conn_id,
    input  wire logic [31:0] i_seqnum,
    input  wire logic [31:0] i_src_network,
    input  wire logic [47:0] i_src_node,
    input  wire logic [15:0] i_src_port,
    input  wire logic [15:0] i_dst_port,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_stall,
    input  wire logic [2:0]  i_action,
    input  wire logic [3:0]  i_slot,
    input  wire logic [31:0] i_reply_conn_id,
    input  wire logic [31:0] i_reply_seqnum,
    input  wire logic [31:0] i_peer_network,
    input  wire logic [47:0] i_peer_node,
    input  wire logic [15:0] i_peer_port,
    input  wire logic [15:0] i_local_port,
    input  wire logic        i_last,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_result_count
);

    typedef struct {
        logic [2:0]  action;
        logic [3:0]  slot;
        logic [31:0] conn_id;
        logic [31:0] seqnum;
        logic [31:0] network;
        logic [47:0] node;
        logic [15:0] peer_port;
        logic [15:0] local_port;
        logic        last;
    } t_reply;

    // Mirror of the connection table and the running counters.
    logic [31:0] conn_ids   [NUM_SLOTS];
    logic [31:0] conn_net   [NUM_SLOTS];
    logic [47:0] conn_node  [NUM_SLOTS];
    logic [15:0] conn_pport [NUM_SLOTS];
    logic [15:0] conn_lport [NUM_SLOTS];
    logic [31:0] conn_seq   [NUM_SLOTS];
    logic [7:0]  conn_tmo   [NUM_SLOTS];
    logic [15:0] sweep_phase;
    logic [31:0] lcg_value;
    logic [15:0] period_reg;
    logic [7:0]  reload_reg;
    logic [15:0] port_reg;

    t_reply replies_due[$];
    int     emitted;

    assign o_pending = replies_due.size();

    function automatic void push_reply(logic [2:0] act, int s, logic [31:0] cid,
                                       logic [31:0] seq, logic [31:0] net,
                                       logic [47:0] node, logic [15:0] pp,
                                       logic [15:0] lp);
        t_reply r;
        r.action = act;
        r.slot = 4'(s);
        r.conn_id = cid;
        r.seqnum = seq;
        r.network = net;
        r.node = node;
        r.peer_port = pp;
        r.local_port = lp;
        r.last = 1'b0;
        replies_due.push_back(r);
        emitted++;
    endfunction

    function automatic void push_entry(logic [2:0] act, int s);
        push_reply(act, s, conn_ids[s], conn_seq[s], conn_net[s], conn_node[s],
                   conn_pport[s], conn_lport[s]);
    endfunction

    // Packet handling: lookup, open, finish, command or reject.
    function automatic void predict_packet();
        int          cur;
        int          free_slot;
        logic [31:0] rid;
        logic [31:0] old;
        logic        rej;
        logic        found;
        cur = -1;
        rid = '0;
        rej = 1'b0;
        found = 1'b0;
        if (i_packet_type != PKT_TYPE) return;
        if (!i_flags[FL_CONLESS]) begin
            rid = i_conn_id;
            for (int n = 0; n < NUM_SLOTS; n++) begin
                if (!found && conn_ids[n] != 0 && conn_ids[n] == i_conn_id) begin
                    found = 1'b1;
                    old = conn_seq[n];
                    cur = n;
                    conn_tmo[n] = reload_reg;
                    conn_seq[n] = old + 1;
                    // A sequence regression closes the connection.
                    if (i_seqnum < old) begin
                        conn_seq[n] = conn_seq[n] + 1;
                        push_entry(ACT_FINISH, n);
                        conn_ids[n] = '0;
                        return;
                    end
                end
            end
            if (cur < 0 && !i_flags[FL_OPEN]) rej = 1'b1;
        end
        if (!rej && i_flags[FL_ACK]) return;
        if (!rej && i_flags[FL_OPEN]) begin
            if (i_flags[FL_FIN] || i_flags[FL_CONLESS] || i_flags[FL_REJ]) begin
                rej = 1'b1;
            end else if (i_dst_port != port_reg) begin
                rej = 1'b1;
            end else begin
                for (int n = 0; n < NUM_SLOTS; n++) begin
                    if (conn_ids[n] != 0 && conn_net[n] == i_src_network
                            && conn_node[n] == i_src_node && conn_pport[n] == i_src_port
                            && conn_lport[n] == i_dst_port)
                        rej = 1'b1;
                end
                free_slot = -1;
                for (int n = NUM_SLOTS - 1; n >= 0; n--) begin
                    if (conn_ids[n] == 0) free_slot = n;
                end
                if (free_slot < 0) rej = 1'b1;
                if (!rej) begin
                    cur = free_slot;
                    rid = lcg_value;
                    conn_ids[cur] = rid;
                    conn_net[cur] = i_src_network;
                    conn_node[cur] = i_src_node;
                    conn_pport[cur] = i_src_port;
                    conn_lport[cur] = i_dst_port;
                    conn_seq[cur] = '0;
                    conn_tmo[cur] = reload_reg;
                    if (!i_flags[FL_CMD]) begin
                        push_reply(ACT_ACK, cur, rid, i_seqnum, i_src_network, i_src_node,
                                   i_src_port, i_dst_port);
                        return;
                    end
                end
            end
        end
        if (!rej && i_flags[FL_FIN]) begin
            if (cur < 0) begin
                rej = 1'b1;
            end else begin
                conn_ids[cur] = '0;
                push_reply(ACT_ACK, cur, rid, i_seqnum, i_src_network, i_src_node,
                           i_src_port, i_dst_port);
                return;
            end
        end
        if (!rej && i_flags[FL_CMD]) begin
            push_reply(ACT_COMMAND, cur < 0 ? 0 : cur, rid, i_seqnum + 1, i_src_network,
                       i_src_node, i_src_port, i_dst_port);
            return;
        end
        push_reply(ACT_REJECT, cur < 0 ? 0 : cur, rid, i_seqnum, i_src_network,
                   i_src_node, i_src_port, i_dst_port);
    endfunction

    // Tick handling: aging sweep at phase zero, then phase and LCG advance.
    function automatic void predict_tick();
        int          cnt;
        logic [2:0]  act;
        logic [16:0] period;
        cnt = 0;
        period = (period_reg == 0) ? 17'd1 : {1'b0, period_reg};
        if (sweep_phase == 0) begin
            for (int n = 0; n < NUM_SLOTS; n++) begin
                if (conn_ids[n] != 0) begin
                    conn_tmo[n] = conn_tmo[n] - 1;
                    conn_seq[n] = conn_seq[n] + 1;
                    act = (conn_tmo[n] == 0) ? ACT_FINISH : ACT_INTERRO;
                    if (cnt < MAX_RESULTS) begin
                        push_entry(act, n);
                        cnt++;
                    end
                    if (act == ACT_FINISH) conn_ids[n] = '0;
                end
            end
        end
        sweep_phase = ({1'b0, sweep_phase} + 17'd1 >= period) ? '0 : sweep_phase + 1;
        lcg_value = lcg_value * LCG_MUL + LCG_ADD;
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s expected 0x%0h, actual 0x%0h", $time, name, want, got);
            o_fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_reply r;
        if (!i_rst_n) begin
            for (int n = 0; n < NUM_SLOTS; n++) conn_ids[n] = '0;
            sweep_phase = '0;
            lcg_value = '0;
            period_reg = TICK_PERIOD_RST;
            reload_reg = TIMEOUT_RST;
            port_reg = '0;
            replies_due.delete();
        end else begin
            // Register writes.
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_TICK_PERIOD:    period_reg = i_cfg_data;
                    CFG_TIMEOUT_RELOAD: reload_reg = i_cfg_data[7:0];
                    CFG_ACCEPTING_PORT: port_reg = i_cfg_data;
                    default: ;
                endcase
            end
            // Accepted input transaction.
            if (i_valid && !i_stall_in) begin
                emitted = 0;
                if (i_func) predict_tick();
                else predict_packet();
                if (emitted > 0) replies_due[replies_due.size() - 1].last = 1'b1;
            end
            // Accepted result transaction.
            if (i_out_valid && !i_out_stall) begin
                o_result_count++;
                if (replies_due.size() == 0) begin
                    $display("%0t: result expected none, actual action %0d slot %0d",
                             $time, i_action, i_slot);
                    o_fail_count++;
                end else begin
                    r = replies_due.pop_front();
                    check_field("action", r.action, i_action);
                    check_field("slot", r.slot, i_slot);
                    check_field("reply_conn_id", r.conn_id, i_reply_conn_id);
                    check_field("reply_seqnum", r.seqnum, i_reply_seqnum);
                    check_field("peer_network", r.network, i_peer_network);
                    check_field("peer_node", r.node, i_peer_node);
                    check_field("peer_port", r.peer_port, i_peer_port);
                    check_field("local_port", r.local_port, i_local_port);
                    check_field("last", r.last, i_last);
                end
            end
        end
    end

    initial begin
        o_fail_count = 0;
        o_result_count = 0;
    end

endmodule

@@ test/connection_table_manager_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// connection_table_manager_tb: stimulus and verdict
// Drives directed and random packets and ticks into the connection table
// manager under several register settings, with random gaps and output
// stalls, and reports the result of the scoreboard.
// ----------------------------------------------------------------------------
module connection_table_manager_tb;
    import ctm_pkg::*;

    localparam int          WATCHDOG_LIMIT = 4000;
    localparam int          SETTLE_CYCLES  = 45;
    localparam logic [5:0]  F_OPEN    = 6'd1 << FL_OPEN;
    localparam logic [5:0]  F_FIN     = 6'd1 << FL_FIN;
    localparam logic [5:0]  F_ACK     = 6'd1 << FL_ACK;
    localparam logic [5:0]  F_REJ     = 6'd1 << FL_REJ;
    localparam logic [5:0]  F_CONLESS = 6'd1 << FL_CONLESS;
    localparam logic [5:0]  F_CMD     = 6'd1 << FL_CMD;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = '0;
    logic [15:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic        i_func = 1'b0;
    logic [7:0]  i_packet_type = '0;
    logic [5:0]  i_flags = '0;
    logic [31:0] i_conn_id = '0;
    logic [31:0] i_seqnum = '0;
    logic [31:0] i_src_network = '0;
    logic [47:0] i_src_node = '0;
    logic [15:0] i_src_port = '0;
    logic [15:0] i_dst_port = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [2:0]  o_action;
    logic [3:0]  o_slot;
    logic [31:0] o_reply_conn_id;
    logic [31:0] o_reply_seqnum;
    logic [31:0] o_peer_network;
    logic [47:0] o_peer_node;
    logic [15:0] o_peer_port;
    logic [15:0] o_local_port;
    logic        o_last;

    int fail_count;
    int pending;
    int result_count;

    connection_table_manager i_dut (.*);

    connection_table_manager_checker i_checker (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_valid, .i_stall_in(o_stall), .i_func, .i_packet_type, .i_flags,
        .i_conn_id, .i_seqnum, .i_src_network, .i_src_node, .i_src_port, .i_dst_port,
        .i_out_valid(o_valid), .i_out_stall(i_stall), .i_action(o_action),
        .i_slot(o_slot), .i_reply_conn_id(o_reply_conn_id),
        .i_reply_seqnum(o_reply_seqnum), .i_peer_network(o_peer_network),
        .i_peer_node(o_peer_node), .i_peer_port(o_peer_port),
        .i_local_port(o_local_port), .i_last(o_last),
        .o_fail_count(fail_count), .o_pending(pending), .o_result_count(result_count)
    );

    always #5 i_clk = ~i_clk;

    // Stimulus bookkeeping: LCG mirror for likely ids, peers and counters.
    logic [31:0] lcg_mirror = '0;
    logic [31:0] id_pool[$];
    logic [31:0] peer_net[4];
    logic [47:0] peer_node[4];
    logic [15:0] peer_port[4];
    logic [15:0] open_port = '0;
    logic        calm = 1'b0;
    int          packets_sent = 0;
    int          ticks_sent = 0;
    int          idle_cycles = 0;
    int          stall_left = 0;

    // Random run lengths: mostly short, a few long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (calm || r < 55) return 0;
        if (r < 92) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // Receiver stalls in runs; calm phases keep it open.
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end else if (calm || $urandom_range(1)) begin
            i_stall <= 1'b0;
            stall_left <= $urandom_range(12);
        end else begin
            i_stall <= 1'b1;
            stall_left <= pick_gap();
        end
    end

    // Watchdog on cycles with no transaction on either channel.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout after %0d idle cycles", idle_cycles);
            $display("connection_table_manager: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Drives one transaction and waits until it is taken; valid stays high
    // afterwards so back-to-back transactions need no extra step.
    task automatic send(logic func, logic [7:0] ptype, logic [5:0] flags,
                        logic [31:0] cid, logic [31:0] seq, logic [31:0] net,
                        logic [47:0] node, logic [15:0] sport, logic [15:0] dport);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_func <= func;
        i_packet_type <= ptype;
        i_flags <= flags;
        i_conn_id <= cid;
        i_seqnum <= seq;
        i_src_network <= net;
        i_src_node <= node;
        i_src_port <= sport;
        i_dst_port <= dport;
        do @(posedge i_clk); while (o_stall);
        if (func) begin
            lcg_mirror = lcg_mirror * LCG_MUL + LCG_ADD;
            ticks_sent++;
        end else begin
            packets_sent++;
            if (flags[FL_OPEN]) begin
                id_pool.push_back(lcg_mirror);
                if (id_pool.size() > 24) void'(id_pool.pop_front());
            end
        end
    endtask

    task automatic tick();
        send(1'b1, 8'($urandom), 6'($urandom), $urandom, $urandom, $urandom,
             {16'($urandom), 32'($urandom)}, 16'($urandom), 16'($urandom));
    endtask

    task automatic packet(logic [5:0] flags, logic [31:0] cid, logic [31:0] seq, int p,
                          logic [15:0] dport);
        send(1'b0, PKT_TYPE, flags, cid, seq, peer_net[p], peer_node[p], peer_port[p],
             dport);
    endtask

    // Drops valid and waits until every result is in and the block is idle.
    task automatic settle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic configure(logic [15:0] period, logic [15:0] reload, logic [15:0] port);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_TICK_PERIOD;
        i_cfg_data <= period;
        @(posedge i_clk);
        i_cfg_idx <= CFG_TIMEOUT_RELOAD;
        i_cfg_data <= reload;
        @(posedge i_clk);
        i_cfg_idx <= CFG_ACCEPTING_PORT;
        i_cfg_data <= port;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        open_port = port;
    endtask

    function automatic logic [31:0] pick_id();
        int r;
        r = $urandom_range(99);
        if (r < 75 && id_pool.size() > 0) return id_pool[$urandom_range(id_pool.size() - 1)];
        if (r < 85) return '0;
        return $urandom;
    endfunction

    // Random phase: mostly well-formed connection traffic, some noise.
    task automatic random_phase(int count);
        int          done;
        int          r;
        int          p;
        logic [5:0]  flags;
        logic [31:0] seq;
        logic [15:0] dport;
        logic [7:0]  ptype;
        done = 0;
        while (done < count) begin
            r = $urandom_range(99);
            p = $urandom_range(3);
            seq = ($urandom_range(6) == 0) ? 32'($urandom_range(3)) : $urandom;
            dport = ($urandom_range(9) == 0) ? 16'($urandom) : open_port;
            if (r < 28) begin
                tick();
                done++;
            end else begin
                if (r < 48) flags = F_OPEN | (($urandom_range(3) == 0) ? F_CMD : 6'd0);
                else if (r < 62) flags = F_CMD;
                else if (r < 70) flags = F_FIN;
                else if (r < 76) flags = F_ACK | 6'($urandom_range(1) ? F_CMD : 6'd0);
                else if (r < 80) flags = F_CONLESS | F_CMD;
                else flags = 6'($urandom);
                ptype = ($urandom_range(19) == 0) ? 8'($urandom) : PKT_TYPE;
                if ($urandom_range(9) == 0) p = 0;
                if ($urandom_range(4) == 0) begin
                    peer_net[p] = $urandom;
                    peer_node[p] = {16'($urandom), 32'($urandom)};
                    peer_port[p] = 16'($urandom);
                end
                send(1'b0, ptype, flags, pick_id(), seq, peer_net[p], peer_node[p],
                     peer_port[p], dport);
                if (ptype == PKT_TYPE) done++;
            end
        end
    endtask

    initial begin
        logic [31:0] first_id;
        logic [31:0] second_id;
        for (int n = 0; n < 4; n++) begin
            peer_net[n] = $urandom;
            peer_node[n] = {16'($urandom), 32'($urandom)};
            peer_port[n] = 16'($urandom);
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part under reset register values (accepting port zero).
        calm = 1'b1;
        packet(F_OPEN, '0, 32'd5, 0, 16'd0);                // open while LCG is zero
        tick();                                             // sweeps at phase zero
        first_id = lcg_mirror;
        packet(F_OPEN, '0, 32'd7, 1, 16'd0);                // new connection
        packet(F_OPEN, '0, 32'd7, 1, 16'd0);                // duplicate peer
        packet(F_OPEN, '0, 32'd7, 2, 16'hFFFF);             // wrong port
        packet(F_OPEN | F_FIN, '0, '0, 2, 16'd0);           // open with finish
        tick();
        second_id = lcg_mirror;
        packet(F_OPEN | F_CMD, '0, 32'd9, 2, 16'd0);        // open with command
        packet(F_CMD, first_id, 32'hFFFF_FFFF, 1, 16'd0);   // dispatch, seq wraps
        packet(F_ACK, first_id, 32'd100, 1, 16'd0);         // no result
        send(1'b0, 8'h00, F_CMD, first_id, '0, '0, '0, '0, '0);   // ignored type
        send(1'b0, 8'hFF, 6'h3F, '1, '1, '1, '1, '1, '1);        // ignored type
        packet(F_CONLESS | F_CMD, '1, 32'd3, 3, 16'hFFFF);  // connectionless command
        packet(F_CONLESS, '0, '0, 3, 16'd0);                // connectionless plain
        packet(F_CMD, 32'hDEAD_BEEF, 32'd4, 3, 16'd0);      // unknown id
        packet(F_REJ, second_id, 32'd50, 2, 16'd0);         // reject flag
        packet(F_CMD, first_id, 32'd0, 1, 16'd0);           // sequence regression
        packet(F_FIN, second_id, 32'd60, 2, 16'd0);         // close on finish
        packet(F_FIN, second_id, 32'd61, 2, 16'd0);         // finish on closed id
        send(1'b0, PKT_TYPE, 6'h3F, '1, '1, '1, '1, '1, '1);
        calm = 1'b0;
        settle();

        // Register settings, extremes among them.
        configure(16'd1, 16'd1, 16'hFFFF);
        random_phase(60);
        settle();
        configure(16'd3, 16'd2, 16'($urandom));
        random_phase(70);
        settle();                                           // full drain mid-traffic
        random_phase(50);
        settle();
        configure(16'd0, 16'd0, 16'h1234);                  // zero period and reload
        random_phase(50);
        settle();
        configure(16'hFFFF, 16'd255, 16'd0);
        random_phase(60);
        settle();
        configure(16'd2, 16'd255, 16'($urandom));           // phase beyond new period
        random_phase(60);
        settle();
        configure(16'd5, 16'd3, 16'($urandom));
        random_phase(60);
        settle();

        $display("ran %0d packets and %0d ticks over seven register settings,",
                 packets_sent, ticks_sent);
        $display("with random gaps and stalls; %0d results compared", result_count);
        if (fail_count == 0) begin
            $display("connection_table_manager: match");
        end else begin
            $display("connection_table_manager: mismatch");
        end
        $finish;
    end

endmodule
